/* sv/rti_pkg.sv */
// Shared types, constants and divider step functions for the ray/triangle intersector.
package rti_pkg;

    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 12;
    localparam int BARY_BITS  = 17;
    localparam int BARY_FRAC  = 16;
    localparam int CFG_BITS   = 32;
    localparam int CFG_IDX_BITS = 3;

    // exact width of every dot product, with headroom
    localparam int W          = 3 * COORD_BITS + 6;
    localparam int DIV_STEPS  = (COORD_BITS > BARY_BITS) ? COORD_BITS : BARY_BITS;
    localparam int NW         = W + DIV_STEPS;
    localparam int GEO_STAGES = 8;

    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIR_Z    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_DET_EPS  = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_T_EPS    = 3'd7;

    localparam logic [2:0] RSN_HIT      = 3'd0;
    localparam logic [2:0] RSN_PARALLEL = 3'd1;
    localparam logic [2:0] RSN_U_OUT    = 3'd2;
    localparam logic [2:0] RSN_V_OUT    = 3'd3;
    localparam logic [2:0] RSN_BEHIND   = 3'd4;

    localparam logic signed [COORD_BITS-1:0] DIR_Z_RESET = COORD_BITS'(1 << FRAC_BITS);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] v0_x;
        logic signed [COORD_BITS-1:0] v0_y;
        logic signed [COORD_BITS-1:0] v0_z;
        logic signed [COORD_BITS-1:0] v1_x;
        logic signed [COORD_BITS-1:0] v1_y;
        logic signed [COORD_BITS-1:0] v1_z;
        logic signed [COORD_BITS-1:0] v2_x;
        logic signed [COORD_BITS-1:0] v2_y;
        logic signed [COORD_BITS-1:0] v2_z;
    } face_t;

    typedef struct packed {
        logic                  hit;
        logic [2:0]            miss_reason;
        logic [COORD_BITS-1:0] dist_t;
        logic [BARY_BITS-1:0]  bary_u;
        logic [BARY_BITS-1:0]  bary_v;
    } res_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] origin_x;
        logic signed [COORD_BITS-1:0] origin_y;
        logic signed [COORD_BITS-1:0] origin_z;
        logic signed [COORD_BITS-1:0] dir_x;
        logic signed [COORD_BITS-1:0] dir_y;
        logic signed [COORD_BITS-1:0] dir_z;
        logic [CFG_BITS-1:0]          det_eps;
    } ray_t;

    // one restoring-division lane: partial remainder plus dividend bits
    // shifting out at the top while quotient bits shift in at the bottom
    typedef struct packed {
        logic [W-1:0]         rem;
        logic [DIV_STEPS-1:0] nq;
    } lane_t;

    typedef struct packed {
        logic [2:0]   reason;
        logic         sat;
        logic [W-1:0] a;
        lane_t        t;
        lane_t        u;
        lane_t        v;
    } div_item_t;

    function automatic lane_t div_init(input logic [NW-1:0] n);
        lane_t y;
        y.rem = n[NW-1:DIV_STEPS];
        y.nq  = n[DIV_STEPS-1:0];
        return y;
    endfunction

    function automatic lane_t div_step(input lane_t x, input logic [W-1:0] d);
        logic [W:0] r2;
        logic [W:0] diff;
        logic       ge;
        lane_t      y;
        r2    = {x.rem, x.nq[DIV_STEPS-1]};
        diff  = r2 - {1'b0, d};
        ge    = (r2 >= {1'b0, d});
        y.rem = ge ? diff[W-1:0] : r2[W-1:0];
        y.nq  = {x.nq[DIV_STEPS-2:0], ge};
        return y;
    endfunction

endpackage

/* sv/rti_geom.sv */
// Geometry pipeline: edges, cross and dot products, sign fix-up and early rejects.
module rti_geom (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rti_pkg::face_t      face_in,
    input  rti_pkg::ray_t       ray,
    output logic                out_valid,
    input  logic                out_ready,
    output rti_pkg::div_item_t  item
);
    import rti_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int E  = C + 1;
    localparam int HW = 2 * C + 2;
    localparam int QW = 2 * C + 3;
    localparam int L  = C + 1;
    localparam int AW = C + 2;
    localparam int BW = C + 3;
    localparam int PW = AW + BW;

    function automatic logic signed [PW-1:0] pmul(input logic signed [AW-1:0] a,
                                                   input logic signed [BW-1:0] b);
        return PW'(a) * PW'(b);
    endfunction

    logic [GEO_STAGES-1:0] v_reg;
    logic [GEO_STAGES-1:0] ld;

    always_comb
    begin
        ld[GEO_STAGES-1] = !v_reg[GEO_STAGES-1] || out_ready;
        for (int k = GEO_STAGES - 2; k >= 0; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    assign in_ready  = ld[0];
    assign out_valid = v_reg[GEO_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < GEO_STAGES; k++)
            begin
                if (ld[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage 1: edges and origin offset
    logic signed [E-1:0] e1_s1_reg [3];
    logic signed [E-1:0] e2_s1_reg [3];
    logic signed [E-1:0] s_s1_reg  [3];

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            e1_s1_reg[0] <= E'(face_in.v1_x) - E'(face_in.v0_x);
            e1_s1_reg[1] <= E'(face_in.v1_y) - E'(face_in.v0_y);
            e1_s1_reg[2] <= E'(face_in.v1_z) - E'(face_in.v0_z);
            e2_s1_reg[0] <= E'(face_in.v2_x) - E'(face_in.v0_x);
            e2_s1_reg[1] <= E'(face_in.v2_y) - E'(face_in.v0_y);
            e2_s1_reg[2] <= E'(face_in.v2_z) - E'(face_in.v0_z);
            s_s1_reg[0]  <= E'(ray.origin_x) - E'(face_in.v0_x);
            s_s1_reg[1]  <= E'(ray.origin_y) - E'(face_in.v0_y);
            s_s1_reg[2]  <= E'(ray.origin_z) - E'(face_in.v0_z);
        end
    end

    // stage 2: cross-product terms
    logic signed [HW-1:0] hp_reg [6];
    logic signed [QW-1:0] qp_reg [6];
    logic signed [E-1:0]  e1_s2_reg [3];
    logic signed [E-1:0]  e2_s2_reg [3];
    logic signed [E-1:0]  s_s2_reg  [3];

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            hp_reg[0] <= HW'(ray.dir_y) * HW'(e2_s1_reg[2]);
            hp_reg[1] <= HW'(ray.dir_z) * HW'(e2_s1_reg[1]);
            hp_reg[2] <= HW'(ray.dir_z) * HW'(e2_s1_reg[0]);
            hp_reg[3] <= HW'(ray.dir_x) * HW'(e2_s1_reg[2]);
            hp_reg[4] <= HW'(ray.dir_x) * HW'(e2_s1_reg[1]);
            hp_reg[5] <= HW'(ray.dir_y) * HW'(e2_s1_reg[0]);
            qp_reg[0] <= QW'(s_s1_reg[1]) * QW'(e1_s1_reg[2]);
            qp_reg[1] <= QW'(s_s1_reg[2]) * QW'(e1_s1_reg[1]);
            qp_reg[2] <= QW'(s_s1_reg[2]) * QW'(e1_s1_reg[0]);
            qp_reg[3] <= QW'(s_s1_reg[0]) * QW'(e1_s1_reg[2]);
            qp_reg[4] <= QW'(s_s1_reg[0]) * QW'(e1_s1_reg[1]);
            qp_reg[5] <= QW'(s_s1_reg[1]) * QW'(e1_s1_reg[0]);
            e1_s2_reg <= e1_s1_reg;
            e2_s2_reg <= e2_s1_reg;
            s_s2_reg  <= s_s1_reg;
        end
    end

    // stage 3: h = dir x e2, q = s x e1
    logic signed [HW-1:0] h_reg [3];
    logic signed [QW-1:0] q_reg [3];
    logic signed [E-1:0]  e1_s3_reg [3];
    logic signed [E-1:0]  e2_s3_reg [3];
    logic signed [E-1:0]  s_s3_reg  [3];

    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            for (int k = 0; k < 3; k++)
            begin
                h_reg[k] <= hp_reg[2*k] - hp_reg[2*k+1];
                q_reg[k] <= qp_reg[2*k] - qp_reg[2*k+1];
            end
            e1_s3_reg <= e1_s2_reg;
            e2_s3_reg <= e2_s2_reg;
            s_s3_reg  <= s_s2_reg;
        end
    end

    // stage 4: dot-product partials, wide operand split at bit L
    // index 3*d+k, d: 0 det, 1 U, 2 V, 3 T
    logic signed [PW-1:0] pl_next [12];
    logic signed [PW-1:0] ph_next [12];
    logic signed [PW-1:0] pl_reg  [12];
    logic signed [PW-1:0] ph_reg  [12];
    logic signed [C-1:0]  dvec [3];

    always_comb
    begin
        logic signed [BW-1:0] hlo;
        logic signed [BW-1:0] hhi;
        logic signed [BW-1:0] qlo;
        logic signed [BW-1:0] qhi;
        dvec[0] = ray.dir_x;
        dvec[1] = ray.dir_y;
        dvec[2] = ray.dir_z;
        for (int k = 0; k < 3; k++)
        begin
            hlo = $signed(BW'({1'b0, h_reg[k][L-1:0]}));
            hhi = BW'($signed(h_reg[k][HW-1:L]));
            qlo = $signed(BW'({1'b0, q_reg[k][L-1:0]}));
            qhi = BW'($signed(q_reg[k][QW-1:L]));
            pl_next[k]   = pmul(AW'(e1_s3_reg[k]), hlo);
            ph_next[k]   = pmul(AW'(e1_s3_reg[k]), hhi);
            pl_next[3+k] = pmul(AW'(s_s3_reg[k]), hlo);
            ph_next[3+k] = pmul(AW'(s_s3_reg[k]), hhi);
            pl_next[6+k] = pmul(AW'(dvec[k]), qlo);
            ph_next[6+k] = pmul(AW'(dvec[k]), qhi);
            pl_next[9+k] = pmul(AW'(e2_s3_reg[k]), qlo);
            ph_next[9+k] = pmul(AW'(e2_s3_reg[k]), qhi);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[3])
        begin
            pl_reg <= pl_next;
            ph_reg <= ph_next;
        end
    end

    // stage 5: recombine partials
    logic signed [W-1:0] term_reg [12];

    always_ff @(posedge clk)
    begin
        if (ld[4])
        begin
            for (int i = 0; i < 12; i++)
            begin
                term_reg[i] <= (W'(ph_reg[i]) <<< L) + W'(pl_reg[i]);
            end
        end
    end

    // stage 6: dot sums
    logic signed [W-1:0] dot_reg [4];

    always_ff @(posedge clk)
    begin
        if (ld[5])
        begin
            for (int d = 0; d < 4; d++)
            begin
                dot_reg[d] <= term_reg[3*d] + term_reg[3*d+1] + term_reg[3*d+2];
            end
        end
    end

    // stage 7: fold the determinant sign into the numerators
    logic signed [W-1:0] a_reg;
    logic signed [W-1:0] un_reg;
    logic signed [W-1:0] vn_reg;
    logic signed [W-1:0] tn_reg;

    always_ff @(posedge clk)
    begin
        if (ld[6])
        begin
            if (dot_reg[0][W-1])
            begin
                a_reg  <= -dot_reg[0];
                un_reg <= -dot_reg[1];
                vn_reg <= -dot_reg[2];
                tn_reg <= -dot_reg[3];
            end
            else
            begin
                a_reg  <= dot_reg[0];
                un_reg <= dot_reg[1];
                vn_reg <= dot_reg[2];
                tn_reg <= dot_reg[3];
            end
        end
    end

    // stage 8: rejects and divider setup
    div_item_t item_next;
    div_item_t item_reg;

    always_comb
    begin
        logic          par;
        logic          uout;
        logic          vout;
        logic          behind;
        logic          sat;
        logic [NW-1:0] nt;
        logic [NW-1:0] nu;
        logic [NW-1:0] nv;
        par    = (a_reg == '0) || (a_reg < $signed(W'(ray.det_eps)));
        uout   = un_reg[W-1] || (un_reg > a_reg);
        vout   = vn_reg[W-1] ||
                 (((W+1)'(un_reg) + (W+1)'(vn_reg)) > (W+1)'(a_reg));
        behind = tn_reg[W-1] || (tn_reg == '0);
        sat    = (tn_reg >>> (C - FRAC_BITS)) >= a_reg;
        nt     = NW'($unsigned(tn_reg)) << FRAC_BITS;
        nu     = NW'($unsigned(un_reg)) << BARY_FRAC;
        nv     = NW'($unsigned(vn_reg)) << BARY_FRAC;

        if (par)
        begin
            item_next.reason = RSN_PARALLEL;
        end
        else if (uout)
        begin
            item_next.reason = RSN_U_OUT;
        end
        else if (vout)
        begin
            item_next.reason = RSN_V_OUT;
        end
        else if (behind)
        begin
            item_next.reason = RSN_BEHIND;
        end
        else
        begin
            item_next.reason = RSN_HIT;
        end

        // only in-range dividends go into the divider, others are zeroed
        item_next.sat = sat;
        item_next.a   = $unsigned(a_reg);
        item_next.t   = div_init((item_next.reason == RSN_HIT && !sat) ? nt : '0);
        item_next.u   = div_init((item_next.reason == RSN_HIT) ? nu : '0);
        item_next.v   = div_init((item_next.reason == RSN_HIT) ? nv : '0);
    end

    always_ff @(posedge clk)
    begin
        if (ld[7])
        begin
            item_reg <= item_next;
        end
    end

    assign item = item_reg;

endmodule

/* sv/rti_div.sv */
// Pipelined restoring divider: one quotient bit per stage for t, u and v in parallel.
module rti_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rti_pkg::div_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output rti_pkg::div_item_t  out_item
);
    import rti_pkg::*;

    logic [DIV_STEPS-1:0] v_reg;
    logic [DIV_STEPS-1:0] ld;
    div_item_t            st_reg [DIV_STEPS];

    genvar i;
    generate
        for (i = 0; i < DIV_STEPS; i++)
        begin : g_stage
            div_item_t src;
            div_item_t nxt;
            logic      src_v;

            if (i == 0)
            begin : g_first
                assign src   = in_item;
                assign src_v = in_valid;
            end
            else
            begin : g_rest
                assign src   = st_reg[i-1];
                assign src_v = v_reg[i-1];
            end

            if (i == DIV_STEPS - 1)
            begin : g_last
                assign ld[i] = !v_reg[i] || out_ready;
            end
            else
            begin : g_mid
                assign ld[i] = !v_reg[i] || ld[i+1];
            end

            always_comb
            begin
                nxt   = src;
                nxt.t = div_step(src.t, src.a);
                nxt.u = div_step(src.u, src.a);
                nxt.v = div_step(src.v, src.a);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[i] <= 1'b0;
                end
                else if (ld[i])
                begin
                    v_reg[i] <= src_v;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ld[i])
                begin
                    st_reg[i] <= nxt;
                end
            end
        end
    endgenerate

    assign in_ready  = ld[0];
    assign out_valid = v_reg[DIV_STEPS-1];
    assign out_item  = st_reg[DIV_STEPS-1];

endmodule

/* sv/ray_triangle_intersect.sv */
// Top level of the ray/triangle intersector: ray registers, pipeline and result register.
//
// Software loads the ray origin, direction and the two thresholds through the
// cfg_we / cfg_index / cfg_data write port, then streams triangles on the face
// channel (face_valid / face_stall / face). Every triangle transaction yields
// exactly one result transaction on the res channel (res_valid / res_stall /
// res): hit, miss reason, distance t and barycentric u, v; a miss sets only the reason.
// The pipeline is 8 geometry stages, one divider stage per quotient bit
// (max(COORD_BITS, 17) = 24 stages) and the result register, 33 registers in all.
// A triangle is accepted every cycle while face_stall is low; the rate is set
// by the fully pipelined multiplier and divider stages.
// Each stage holds its item until the next stage frees up, so bubbles close up
// and input is taken until every stage is full; when res_stall stays high the
// result is held unchanged and face_stall rises once the pipeline has filled.
// Reset empties the pipeline and loads the ray registers with origin 0,
// direction +z (1.0), det_epsilon 1 and t_epsilon 1. Registers are to be
// written only while no triangle is in flight.
module ray_triangle_intersect (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rti_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [rti_pkg::CFG_BITS-1:0]      cfg_data,
    input  logic                              face_valid,
    output logic                              face_stall,
    input  rti_pkg::face_t                    face,
    output logic                              res_valid,
    input  logic                              res_stall,
    output rti_pkg::res_t                     res
);
    import rti_pkg::*;

    localparam int C = COORD_BITS;

    ray_t                  ray_reg;
    logic [C-1:0]          t_eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_reg.origin_x <= '0;
            ray_reg.origin_y <= '0;
            ray_reg.origin_z <= '0;
            ray_reg.dir_x    <= '0;
            ray_reg.dir_y    <= '0;
            ray_reg.dir_z    <= DIR_Z_RESET;
            ray_reg.det_eps  <= CFG_BITS'(1);
            t_eps_reg        <= C'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN_X: ray_reg.origin_x <= cfg_data[C-1:0];
                REG_ORIGIN_Y: ray_reg.origin_y <= cfg_data[C-1:0];
                REG_ORIGIN_Z: ray_reg.origin_z <= cfg_data[C-1:0];
                REG_DIR_X:    ray_reg.dir_x    <= cfg_data[C-1:0];
                REG_DIR_Y:    ray_reg.dir_y    <= cfg_data[C-1:0];
                REG_DIR_Z:    ray_reg.dir_z    <= cfg_data[C-1:0];
                REG_DET_EPS:  ray_reg.det_eps  <= cfg_data;
                REG_T_EPS:    t_eps_reg        <= cfg_data[C-1:0];
                default:      ;
            endcase
        end
    end

    logic       geo_ready;
    logic       geo_valid;
    div_item_t  geo_item;
    logic       div_ready;
    logic       div_valid;
    div_item_t  div_item;
    logic       out_ld;

    rti_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (face_valid),
        .in_ready  (geo_ready),
        .face_in   (face),
        .ray       (ray_reg),
        .out_valid (geo_valid),
        .out_ready (div_ready),
        .item      (geo_item)
    );

    rti_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (geo_valid),
        .in_ready  (div_ready),
        .in_item   (geo_item),
        .out_valid (div_valid),
        .out_ready (out_ld),
        .out_item  (div_item)
    );

    assign face_stall = !geo_ready;

    // result register
    logic  res_valid_reg;
    res_t  res_reg;
    res_t  res_next;

    assign out_ld = !res_valid_reg || !res_stall;

    always_comb
    begin
        logic [C-1:0] tq;
        tq = div_item.sat ? {C{1'b1}} : div_item.t.nq[C-1:0];
        res_next = '0;
        if (div_item.reason != RSN_HIT)
        begin
            res_next.miss_reason = div_item.reason;
        end
        else if (tq <= t_eps_reg)
        begin
            res_next.miss_reason = RSN_BEHIND;
        end
        else
        begin
            res_next.hit         = 1'b1;
            res_next.miss_reason = RSN_HIT;
            res_next.dist_t      = tq;
            res_next.bary_u      = div_item.u.nq[BARY_BITS-1:0];
            res_next.bary_v      = div_item.v.nq[BARY_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_ld)
        begin
            res_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ld)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.hit == (res.miss_reason == RSN_HIT)))
        else $error("hit flag disagrees with miss reason");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.hit) |->
            (res.dist_t == '0 && res.bary_u == '0 && res.bary_v == '0))
        else $error("miss result carries nonzero payload");

    a_bary_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.hit) |->
            ((BARY_BITS+1)'(res.bary_u) + (BARY_BITS+1)'(res.bary_v)
                <= (BARY_BITS+1)'(1 << BARY_FRAC)))
        else $error("barycentric sum above one");

    a_t_eps: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.hit) |-> (res.dist_t > t_eps_reg))
        else $error("hit with distance not above t epsilon");

    a_reason_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.miss_reason <= RSN_BEHIND))
        else $error("miss reason out of range");

endmodule
